### rtl/n2a_pkg.sv
package n2a_pkg;

    // Default fixed-point format: Q12 with five fraction digits.
    localparam int FRACTION_BITS_DEF   = 12;
    localparam int FRACTION_DIGITS_DEF = 5;

    // Longest text that is emitted for one value.
    localparam int MAX_RESULTS = 13;

    // Decimal digits of a 32-bit magnitude, and the counter that walks them.
    localparam int DIGIT_DEPTH = 10;
    localparam int CNT_W       = 4;

    // Reciprocal of ten for the constant divider: q = (a * RECIP) >> 35.
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // Format selector codes.
    localparam logic [1:0] MODE_SDEC  = 2'd0;
    localparam logic [1:0] MODE_UDEC  = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;
    localparam logic [1:0] MODE_FIXED = 2'd3;

    // Hex digit count codes; the spare code is read as eight digits.
    localparam logic [1:0] HW_TWO   = 2'd0;
    localparam logic [1:0] HW_FOUR  = 2'd1;
    localparam logic [1:0] HW_EIGHT = 2'd2;
    localparam logic [1:0] HW_SPARE = 2'd3;

    // Punctuation characters.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;

    // Digit characters, first character in the top byte.
    localparam logic [127:0] DIGIT_CHARS = "0123456789ABCDEF";

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIGN,
        PH_DIV,
        PH_INT,
        PH_POINT,
        PH_FRAC,
        PH_HEX
    } phase_t;

    // Operations of the shared digit unit.
    typedef enum logic [1:0] {
        UOP_DIV10,
        UOP_MUL10,
        UOP_SHL4
    } unit_op_t;

    // One character request from the sequencer to the output stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] code;
        logic       last;
    } char_req_t;

    // ASCII character of one digit.
    function automatic logic [7:0] hex_char(input logic [3:0] digit);
        logic [6:0] base;
        base = 7'(7'd120 - {digit, 3'b000});
        return DIGIT_CHARS[base +: 8];
    endfunction

endpackage

### rtl/n2a_digit_unit.sv
// Shared digit unit: one step of decimal or hex digit extraction.
module n2a_digit_unit #(
    parameter int FRACTION_BITS = n2a_pkg::FRACTION_BITS_DEF
) (
    input  n2a_pkg::unit_op_t op,
    input  logic [31:0]       operand,
    output logic [31:0]       result,
    output logic [3:0]        digit
);

    logic [63:0]              prod;
    logic [28:0]              quot;
    logic [31:0]              rem_full;
    logic [FRACTION_BITS+3:0] frac_x10;

    // Division by ten through the reciprocal, then the remainder by shift and add.
    assign prod     = 64'(operand) * 64'(n2a_pkg::DIV10_RECIP);
    assign quot     = prod[63:n2a_pkg::DIV10_SHIFT];
    assign rem_full = operand - ({quot, 3'b000} + {2'b00, quot, 1'b0});

    // Fraction times ten: the integer part is the next fraction digit.
    assign frac_x10 = {operand[FRACTION_BITS-1:0], 3'b000}
                    + {3'b000, operand[FRACTION_BITS-1:0], 1'b0};

    // Select the operation in use.
    always_comb
    begin
        case (op)
            n2a_pkg::UOP_DIV10:
            begin
                result = {3'b000, quot};
                digit  = rem_full[3:0];
            end
            n2a_pkg::UOP_MUL10:
            begin
                result = {{(32-FRACTION_BITS){1'b0}}, frac_x10[FRACTION_BITS-1:0]};
                digit  = frac_x10[FRACTION_BITS+3:FRACTION_BITS];
            end
            n2a_pkg::UOP_SHL4:
            begin
                result = {operand[27:0], 4'h0};
                digit  = operand[31:28];
            end
            default:
            begin
                result = operand;
                digit  = 4'h0;
            end
        endcase
    end

endmodule

### rtl/n2a_out_reg.sv
// Output register: holds one character until the sink takes it.
module n2a_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  n2a_pkg::char_req_t req,
    output logic               room,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // char_out[7:0]
    output logic               m_tlast
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] code_reg;
    logic       last_reg;

    // The stage can load whenever it is empty or being emptied.
    assign room = !valid_reg || m_tready;

    always_comb
    begin
        if (req.valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Character payload, loaded with each request.
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            code_reg <= req.code;
            last_reg <= req.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = code_reg;
    assign m_tlast  = last_reg;

endmodule

### rtl/number_to_ascii_converter_core.sv
// Channel  Group     Dir  Payload
// input    s_*       in   tdata: value[31:0]; tuser: mode[1:0], hex_width[3:2], show_plus[4]
// output   m_*       out  tdata: char_out[7:0]; tlast: last
//
// One value is accepted, then an optional sign is emitted; the shared digit
// unit divides by ten until the integer digits are in the scratch store, and
// they are emitted most significant first; fixed point adds the point and the
// fraction digits, and hex emits its digits straight from the digit unit.
// A new request is taken only while the sequencer is idle. A stalled sink
// freezes the sequencer on emitting cycles; the divide cycles run on regardless.
// rst_n clears the sequencer and the output valid flag asynchronously.
module number_to_ascii_converter_core #(
    parameter int FRACTION_BITS   = n2a_pkg::FRACTION_BITS_DEF,
    parameter int FRACTION_DIGITS = n2a_pkg::FRACTION_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // value[31:0]
    input  logic [4:0]  s_tuser,    // mode[1:0], hex_width[3:2], show_plus[4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // char_out[7:0]
    output logic        m_tlast     // last
);

    localparam int CW = n2a_pkg::CNT_W;

    n2a_pkg::phase_t          phase_reg;
    n2a_pkg::phase_t          phase_next;
    logic [31:0]              work_reg;
    logic [31:0]              work_next;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic [FRACTION_BITS-1:0] frac_next;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    logic [CW-1:0]            chars_reg;
    logic [CW-1:0]            chars_next;
    logic                     fixed_reg;
    logic                     fixed_next;
    logic [7:0]               sign_reg;
    logic [7:0]               sign_next;
    logic [3:0]               digit_store [n2a_pkg::DIGIT_DEPTH];
    logic                     store_we;

    n2a_pkg::unit_op_t        unit_op;
    logic [31:0]              unit_result;
    logic [3:0]               unit_digit;
    n2a_pkg::char_req_t       req;
    logic                     room;
    logic                     natural_last;

    logic [1:0]               in_mode;
    logic [1:0]               in_hw;
    logic                     in_plus;
    logic                     signed_mode;
    logic                     neg;
    logic [31:0]              mag;

    // Request fields and the magnitude in the signed modes.
    assign in_mode     = s_tuser[1:0];
    assign in_hw       = s_tuser[3:2];
    assign in_plus     = s_tuser[4];
    assign signed_mode = (in_mode == n2a_pkg::MODE_SDEC) || (in_mode == n2a_pkg::MODE_FIXED);
    assign neg         = signed_mode && s_tdata[31];
    assign mag         = neg ? (32'd0 - s_tdata) : s_tdata;

    assign s_tready = (phase_reg == n2a_pkg::PH_IDLE);

    // Shared digit unit.
    always_comb
    begin
        case (phase_reg)
            n2a_pkg::PH_FRAC: unit_op = n2a_pkg::UOP_MUL10;
            n2a_pkg::PH_HEX:  unit_op = n2a_pkg::UOP_SHL4;
            default:          unit_op = n2a_pkg::UOP_DIV10;
        endcase
    end

    n2a_digit_unit #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_unit (
        .op      (unit_op),
        .operand (work_reg),
        .result  (unit_result),
        .digit   (unit_digit)
    );

    // Sequencer: next phase, datapath updates and character requests.
    always_comb
    begin
        phase_next   = phase_reg;
        work_next    = work_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        chars_next   = chars_reg;
        fixed_next   = fixed_reg;
        sign_next    = sign_reg;
        store_we     = 1'b0;
        natural_last = 1'b0;
        req.valid    = 1'b0;
        req.code     = n2a_pkg::CH_POINT;

        case (phase_reg)
            n2a_pkg::PH_IDLE:
            begin
                if (s_tvalid)
                begin
                    chars_next = '0;
                    fixed_next = (in_mode == n2a_pkg::MODE_FIXED);
                    frac_next  = mag[FRACTION_BITS-1:0];
                    sign_next  = neg ? n2a_pkg::CH_MINUS : n2a_pkg::CH_PLUS;
                    if (in_mode == n2a_pkg::MODE_HEX)
                    begin
                        phase_next = n2a_pkg::PH_HEX;
                        case (in_hw)
                            n2a_pkg::HW_TWO:
                            begin
                                work_next = {s_tdata[7:0], 24'd0};
                                cnt_next  = CW'(2);
                            end
                            n2a_pkg::HW_FOUR:
                            begin
                                work_next = {s_tdata[15:0], 16'd0};
                                cnt_next  = CW'(4);
                            end
                            default:
                            begin
                                work_next = s_tdata;
                                cnt_next  = CW'(8);
                            end
                        endcase
                    end
                    else
                    begin
                        cnt_next  = '0;
                        work_next = (in_mode == n2a_pkg::MODE_FIXED) ? (mag >> FRACTION_BITS)
                                                                     : mag;
                        if (signed_mode && (neg || in_plus))
                        begin
                            phase_next = n2a_pkg::PH_SIGN;
                        end
                        else
                        begin
                            phase_next = n2a_pkg::PH_DIV;
                        end
                    end
                end
            end
            n2a_pkg::PH_SIGN:
            begin
                req.valid = room;
                req.code  = sign_reg;
                if (room)
                begin
                    phase_next = n2a_pkg::PH_DIV;
                end
            end
            n2a_pkg::PH_DIV:
            begin
                store_we  = 1'b1;
                work_next = unit_result;
                cnt_next  = cnt_reg + CW'(1);
                if ((unit_result == 32'd0) || (cnt_reg == CW'(n2a_pkg::DIGIT_DEPTH - 1)))
                begin
                    phase_next = n2a_pkg::PH_INT;
                end
            end
            n2a_pkg::PH_INT:
            begin
                req.valid    = room;
                req.code     = n2a_pkg::hex_char(digit_store[cnt_reg - CW'(1)]);
                natural_last = (cnt_reg == CW'(1)) && !fixed_reg;
                if (room)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        phase_next = fixed_reg ? n2a_pkg::PH_POINT : n2a_pkg::PH_IDLE;
                    end
                end
            end
            n2a_pkg::PH_POINT:
            begin
                req.valid = room;
                req.code  = n2a_pkg::CH_POINT;
                if (room)
                begin
                    work_next  = 32'(frac_reg);
                    cnt_next   = CW'(FRACTION_DIGITS);
                    phase_next = n2a_pkg::PH_FRAC;
                end
            end
            n2a_pkg::PH_FRAC, n2a_pkg::PH_HEX:
            begin
                req.valid    = room;
                req.code     = n2a_pkg::hex_char(unit_digit);
                natural_last = (cnt_reg == CW'(1));
                if (room)
                begin
                    work_next = unit_result;
                    cnt_next  = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        phase_next = n2a_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = n2a_pkg::PH_IDLE;
            end
        endcase

        // The last character is the natural end or the length limit.
        req.last = natural_last || (chars_reg == CW'(n2a_pkg::MAX_RESULTS - 1));
        if (req.valid)
        begin
            chars_next = chars_reg + CW'(1);
            if (req.last)
            begin
                phase_next = n2a_pkg::PH_IDLE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= n2a_pkg::PH_IDLE;
            work_reg  <= '0;
            cnt_reg   <= '0;
            chars_reg <= '0;
            fixed_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            work_reg  <= work_next;
            cnt_reg   <= cnt_next;
            chars_reg <= chars_next;
            fixed_reg <= fixed_next;
        end
    end

    // Payload registers and the digit scratch store.
    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
        sign_reg <= sign_next;
        if (store_we)
        begin
            digit_store[cnt_reg] <= unit_digit;
        end
    end

    n2a_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // No more than the length limit of characters for one value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != n2a_pkg::PH_IDLE) |-> (chars_reg < CW'(n2a_pkg::MAX_RESULTS)))
        else $error("character count passed the length limit");

    // An accepted request keeps the input closed on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened straight after a request");

    // The final character returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.last) |=> (phase_reg == n2a_pkg::PH_IDLE))
        else $error("sequencer busy after the final character");

    // Digit extraction stays inside the scratch store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == n2a_pkg::PH_DIV) |-> (cnt_reg < CW'(n2a_pkg::DIGIT_DEPTH)))
        else $error("digit index outside the scratch store");

    // No character is requested while digits are being extracted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == n2a_pkg::PH_DIV) |-> !req.valid)
        else $error("character request during digit extraction");

endmodule
